/* rtl/core/afpc_pkg.sv */
// Shared constants and types of the box versus frustum plane test.
`default_nettype none

package afpc_pkg;

  localparam int CFG_COUNT = 6;
  localparam int CFG_IDX_W = 3;
  localparam int PLANE_W = 64;
  localparam int MASK_W = 6;
  localparam int NUM_PLANES_DEF = 6;
  localparam int COORD_WIDTH_DEF = 16;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } lane_en_t;

endpackage

`default_nettype wire

/* rtl/core/aabb_frustum_plane_clip_unit.sv */
// Top level of the box versus frustum plane test with its stream pipeline.
// Throughput: one box per cycle while the output is not stalled; each plane has its own multiplier lane.
// The four stages are input register, multiply, sum and test; each stalls
// only when it and all stages after it hold data.
// Reset clears the valid bits and all plane registers to zero.
`default_nettype none

module aabb_frustum_plane_clip_unit #(
  parameter int NUM_PLANES = afpc_pkg::NUM_PLANES_DEF,
  parameter int COORD_WIDTH = afpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // center_x, center_y, center_z, corner_x, corner_y, corner_z, active_planes
  input  logic [((6*COORD_WIDTH+afpc_pkg::MASK_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // visible, straddle_mask
  output logic [7:0]                                  m_axis_tdata,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [afpc_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [afpc_pkg::PLANE_W-1:0]                cfg_data
);
  import afpc_pkg::*;

  localparam int LANES = (NUM_PLANES < CFG_COUNT) ? NUM_PLANES : CFG_COUNT;
  localparam int CW = COORD_WIDTH;

  logic [LANES-1:0][PLANE_W-1:0] planes;

  logic v1, v2, v3, v4;
  logic load1, load2, load3, load4;
  lane_en_t lane_en;

  logic [2:0][CW-1:0] cen_in;
  logic [2:0][CW-1:0] cor_in;
  logic [2:0][CW-1:0] cen1;
  logic [2:0][CW:0]   half1;
  logic [MASK_W-1:0]  act1;

  logic [LANES-1:0]   behind;
  logic [LANES-1:0]   straddle;
  logic               visible;
  logic [MASK_W-1:0]  out_mask;

  assign cfg_ready = 1'b1;

  afpc_plane_regs #(
    .LANES(LANES)
  ) u_regs (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .planes(planes)
  );

  assign load4 = !v4 || m_axis_tready;
  assign load3 = !v3 || load4;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;
  assign s_axis_tready = load1;

  assign lane_en.s2 = load2;
  assign lane_en.s3 = load3;
  assign lane_en.s4 = load4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (load1) v1 <= s_axis_tvalid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) v4 <= v3;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cen_in[k] = s_axis_tdata[CW*k +: CW];
      cor_in[k] = s_axis_tdata[CW*(k+3) +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      for (int k = 0; k < 3; k++) begin
        cen1[k] <= cen_in[k];
        half1[k] <= (CW + 1)'($signed(cor_in[k])) - (CW + 1)'($signed(cen_in[k]));
      end
      act1 <= s_axis_tdata[6*CW +: MASK_W];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    afpc_plane_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk(clk),
      .en(lane_en),
      .plane(planes[i]),
      .cen(cen1),
      .half(half1),
      .active(act1[i]),
      .behind(behind[i]),
      .straddle(straddle[i])
    );
  end

  assign visible = ~|behind;
  assign out_mask = visible ? MASK_W'(straddle) : '0;

  assign m_axis_tvalid = v4;
  assign m_axis_tdata = {1'b0, out_mask, visible};

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v4 && !m_axis_tready |=> v4)
    else $error("Result was dropped while the output was stalled.");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> v1 && v2 && v3 && v4)
    else $error("Input blocked while the pipeline has an empty stage.");

  a_hidden_no_straddle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == '0)
    else $error("Straddle bits set on a box that is not visible.");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v3 && load4 |=> v4)
    else $error("A valid item failed to advance into the output stage.");

endmodule

`default_nettype wire

/* rtl/core/afpc_plane_regs.sv */
// Configuration register file holding the packed frustum planes.
`default_nettype none

module afpc_plane_regs #(
  parameter int LANES = afpc_pkg::NUM_PLANES_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            cfg_valid,
  input  logic [afpc_pkg::CFG_IDX_W-1:0]                  cfg_index,
  input  logic [afpc_pkg::PLANE_W-1:0]                    cfg_data,
  output logic [LANES-1:0][afpc_pkg::PLANE_W-1:0]         planes
);
  import afpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      planes <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < LANES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          planes[i] <= cfg_data;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/afpc_plane_lane.sv */
// One plane lane: products, distance sums and the behind and straddle tests.
`default_nettype none

module afpc_plane_lane #(
  parameter int COORD_WIDTH = afpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  afpc_pkg::lane_en_t                 en,
  input  logic [afpc_pkg::PLANE_W-1:0]       plane,
  input  logic [2:0][COORD_WIDTH-1:0]        cen,
  input  logic [2:0][COORD_WIDTH:0]          half,
  input  logic                               active,
  output logic                               behind,
  output logic                               straddle
);
  import afpc_pkg::*;

  localparam int NP_W = COORD_WIDTH + 18;
  localparam int MP_W = COORD_WIDTH + 16;
  localparam int ACC_W = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 20;

  logic signed [2:0][15:0] nrm;
  logic signed [2:0][16:0] nabs;
  logic signed [16:0]      nx [3];

  logic signed [NP_W-1:0]  np_term [3];
  logic signed [MP_W-1:0]  mp_term [3];
  logic signed [15:0]      w2;
  logic                    act2;

  logic signed [ACC_W-1:0] np_sum;
  logic signed [ACC_W-1:0] mp_sum;
  logic                    act3;

  logic signed [ACC_W:0]   far_dist;
  logic signed [ACC_W:0]   near_dist;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nrm[k] = plane[16*k +: 16];
      nx[k] = {nrm[k][15], nrm[k]};
      nabs[k] = nx[k][16] ? -nx[k] : nx[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int k = 0; k < 3; k++) begin
        np_term[k] <= $signed(half[k]) * $signed(nabs[k]);
        mp_term[k] <= $signed(cen[k]) * $signed(nrm[k]);
      end
      w2 <= plane[63:48];
      act2 <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      np_sum <= ACC_W'(np_term[0]) + ACC_W'(np_term[1]) + ACC_W'(np_term[2]);
      mp_sum <= ACC_W'(mp_term[0]) + ACC_W'(mp_term[1]) + ACC_W'(mp_term[2])
              + ACC_W'($signed({w2, 14'b0}));
      act3 <= act2;
    end
  end

  assign far_dist = (ACC_W + 1)'(mp_sum) + (ACC_W + 1)'(np_sum);
  assign near_dist = (ACC_W + 1)'(mp_sum) - (ACC_W + 1)'(np_sum);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      behind <= act3 & far_dist[ACC_W];
      straddle <= act3 & near_dist[ACC_W];
    end
  end

endmodule

`default_nettype wire

/* dv/aabb_frustum_plane_clip_unit_tb.sv */
// Self-checking stream testbench for the box versus frustum plane clip unit.
`timescale 1ns / 100ps

module aabb_frustum_plane_clip_unit_tb;

  localparam int IN_W = ((6*afpc_pkg::COORD_WIDTH_DEF+afpc_pkg::MASK_W+7)/8)*8;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_PRINTS = 40;

  typedef enum logic [afpc_pkg::CFG_IDX_W-1:0] {
    PLANE_FRONT, PLANE_BACK, PLANE_LEFT, PLANE_RIGHT, PLANE_TOP, PLANE_BOTTOM,
    PLANE_SPARE6, PLANE_SPARE7
  } plane_sel_e;

  typedef struct packed {
    logic [afpc_pkg::MASK_W-1:0] act;
    logic signed [15:0] kz, ky, kx;
    logic signed [15:0] cz, cy, cx;
  } box_t;

  typedef struct packed {
    logic vis;
    logic [afpc_pkg::MASK_W-1:0] mask;
  } verdict_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [afpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [afpc_pkg::PLANE_W-1:0] cfg_data;

  logic [63:0] plane_q [afpc_pkg::CFG_COUNT];
  verdict_t verdict_q [$];
  int n_errors;
  int n_boxes;
  int n_culled;
  int n_straddled;
  int n_cfg;
  int src_gap_pct;
  int sink_stall_pct;
  int quiet_cycles;

  aabb_frustum_plane_clip_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic verdict_t cull_box(box_t b);
    longint c [3];
    longint h [3];
    longint n [3];
    longint w;
    longint np;
    longint mp;
    logic [63:0] p;
    logic culled;
    verdict_t v;
    c[0] = $signed(b.cx);
    c[1] = $signed(b.cy);
    c[2] = $signed(b.cz);
    h[0] = longint'($signed(b.kx)) - c[0];
    h[1] = longint'($signed(b.ky)) - c[1];
    h[2] = longint'($signed(b.kz)) - c[2];
    culled = 1'b0;
    v.vis = 1'b1;
    v.mask = '0;
    for (int i = 0; i < afpc_pkg::CFG_COUNT; i++) begin
      if (b.act[i] && !culled) begin
        p = plane_q[i];
        n[0] = $signed(p[15:0]);
        n[1] = $signed(p[31:16]);
        n[2] = $signed(p[47:32]);
        w = $signed(p[63:48]);
        mp = w * 16384;
        np = 0;
        for (int k = 0; k < 3; k++) begin
          np += h[k] * ((n[k] < 0) ? -n[k] : n[k]);
          mp += c[k] * n[k];
        end
        if (mp + np < 0) begin
          culled = 1'b1;
        end else if (mp - np < 0) begin
          v.mask[i] = 1'b1;
        end
      end
    end
    if (culled) begin
      v.vis = 1'b0;
      v.mask = '0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (n_errors < MAX_PRINTS) begin
      $display("MISMATCH at result %0d, %s: got %0h, expected %0h", n_boxes, field, got, want);
    end
    n_errors++;
  endtask

  // Transaction monitor: mirrors plane writes, predicts on each accepted box and checks each result.
  always @(posedge clk) begin
    verdict_t want;
    box_t b;
    if (rst) begin
      for (int i = 0; i < afpc_pkg::CFG_COUNT; i++) begin
        plane_q[i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        if (cfg_index < afpc_pkg::CFG_COUNT) begin
          plane_q[cfg_index] = cfg_data;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        b = box_t'(s_axis_tdata[$bits(box_t)-1:0]);
        verdict_q.push_back(cull_box(b));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no box pending", m_axis_tdata, 0);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.vis) begin
            report_mismatch("visible", m_axis_tdata[0], want.vis);
          end
          if (m_axis_tdata[6:1] !== want.mask) begin
            report_mismatch("straddle_mask", m_axis_tdata[6:1], want.mask);
          end
          if (!want.vis) n_culled++;
          if (want.mask != 0) n_straddled++;
        end
        n_boxes++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results pending",
               QUIET_LIMIT, verdict_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result sink with random stall bursts.
  initial begin
    int burst;
    burst = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall_pct == 0) burst = 0;
      if (burst > 0) begin
        m_axis_tready <= 1'b0;
        burst--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < sink_stall_pct) burst = $urandom_range(1, 17);
      end
    end
  end

  task automatic send_box(box_t b);
    int gap;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W-$bits(box_t)){1'b0}}, b};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_fields(int cx, int cy, int cz, int kx, int ky, int kz, int act);
    box_t b;
    b.cx = 16'(cx);
    b.cy = 16'(cy);
    b.cz = 16'(cz);
    b.kx = 16'(kx);
    b.ky = 16'(ky);
    b.kz = 16'(kz);
    b.act = 6'(act);
    send_box(b);
  endtask

  task automatic quiesce();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_plane(plane_sel_e sel, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_planes(input logic [63:0] planes [afpc_pkg::CFG_COUNT]);
    quiesce();
    for (int i = 0; i < afpc_pkg::CFG_COUNT; i++) begin
      write_plane(plane_sel_e'(i), planes[i]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] plane_word(int nx, int ny, int nz, int w);
    return {16'(w), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic logic signed [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 7);
    if (r < 4) return 16'($urandom);
    if (r < 7) return 16'($urandom_range(0, 4000) - 2000);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_corner(logic signed [15:0] c);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return c + 16'($urandom_range(0, 1023));
    if (r < 8) return 16'($urandom);
    if (r < 9) return c - 16'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic box_t random_box();
    box_t b;
    int r;
    b.cx = rand_coord();
    b.cy = rand_coord();
    b.cz = rand_coord();
    b.kx = rand_corner(b.cx);
    b.ky = rand_corner(b.cy);
    b.kz = rand_corner(b.cz);
    r = $urandom_range(0, 19);
    if (r < 14) b.act = 6'($urandom);
    else if (r < 17) b.act = '1;
    else b.act = 6'(1 << $urandom_range(0, 5));
    return b;
  endfunction

  function automatic logic [63:0] rand_plane();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return {16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 32768) - 16384),
            16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384)};
  endfunction

  task automatic send_random(int count);
    repeat (count) send_box(random_box());
  endtask

  task automatic test_reset_planes();
    src_gap_pct = 20;
    sink_stall_pct = 20;
    send_fields(0, 0, 0, 10, 10, 10, 'h3F);
    send_fields(100, -100, 50, 90, -110, 40, 'h3F);
    send_fields(-32768, 32767, 0, 32767, -32768, 0, 'h2A);
    send_fields(5, 5, 5, 5, 5, 5, 'h00);
  endtask

  task automatic test_axis_cube();
    logic [63:0] cube [afpc_pkg::CFG_COUNT];
    cube[PLANE_FRONT] = plane_word(0, 0, 16384, 1000);
    cube[PLANE_BACK] = plane_word(0, 0, -16384, 1000);
    cube[PLANE_LEFT] = plane_word(16384, 0, 0, 1000);
    cube[PLANE_RIGHT] = plane_word(-16384, 0, 0, 1000);
    cube[PLANE_TOP] = plane_word(0, -16384, 0, 1000);
    cube[PLANE_BOTTOM] = plane_word(0, 16384, 0, 1000);
    load_planes(cube);
    send_fields(0, 0, 0, 10, 10, 10, 'h3F);
    send_fields(990, 0, 0, 1020, 10, 10, 'h3F);
    send_fields(2000, 0, 0, 2010, 10, 10, 'h3F);
    send_fields(2000, 0, 0, 2010, 10, 10, 'h37);
    send_fields(0, 0, 0, 10, 10, 10, 'h00);
    send_fields(-32768, -32768, -32768, 32767, 32767, 32767, 'h3F);
    send_fields(32767, 32767, 32767, 32767, 32767, 32767, 'h3F);
    send_fields(0, 0, 0, -10, -10, -10, 'h3F);
    send_fields(995, 0, 0, 985, -10, -10, 'h3F);
    send_fields(0, 0, -995, 5, 5, -985, 'h3F);
    send_fields(0, 999, 0, 1, 1001, 1, 'h10);
    send_fields(-32768, 0, 0, -32768, 0, 0, 'h01);
    send_fields(0, 0, 0, 32767, 32767, 32767, 'h3F);
    send_fields(0, -1001, 0, 0, -1001, 0, 'h20);
  endtask

  task automatic test_extreme_planes();
    logic [63:0] planes [afpc_pkg::CFG_COUNT];
    for (int i = 0; i < afpc_pkg::CFG_COUNT; i++) planes[i] = 64'h8000_8000_8000_8000;
    load_planes(planes);
    write_plane(PLANE_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF);
    write_plane(PLANE_SPARE7, 64'h1234_5678_9ABC_DEF0);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_random(40);
    for (int i = 0; i < afpc_pkg::CFG_COUNT; i++) planes[i] = 64'h7FFF_7FFF_7FFF_7FFF;
    load_planes(planes);
    send_random(40);
  endtask

  task automatic test_random_planes();
    logic [63:0] planes [afpc_pkg::CFG_COUNT];
    int gap_pct [5];
    int stall_pct [5];
    gap_pct = '{15, 0, 40, 5, 30};
    stall_pct = '{15, 0, 40, 30, 5};
    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < afpc_pkg::CFG_COUNT; i++) planes[i] = rand_plane();
      load_planes(planes);
      src_gap_pct = gap_pct[ph];
      sink_stall_pct = stall_pct[ph];
      send_random(300);
    end
  endtask

  task automatic test_streaming_tail();
    logic [63:0] planes [afpc_pkg::CFG_COUNT];
    for (int i = 0; i < afpc_pkg::CFG_COUNT; i++) planes[i] = rand_plane();
    load_planes(planes);
    src_gap_pct = 0;
    sink_stall_pct = 0;
    send_random(120);
  endtask

  initial begin
    n_errors = 0;
    n_boxes = 0;
    n_culled = 0;
    n_straddled = 0;
    n_cfg = 0;
    quiet_cycles = 0;
    src_gap_pct = 0;
    sink_stall_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = PLANE_FRONT;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_planes();
    test_axis_cube();
    test_extreme_planes();
    test_random_planes();
    test_streaming_tail();
    quiesce();

    $display("Checked %0d boxes over 10 plane sets with %0d register writes.", n_boxes, n_cfg);
    $display("Culled %0d boxes, %0d results had straddled planes, %0d mismatches.",
             n_culled, n_straddled, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
